// ----- design/twsv_pkg.sv -----
`timescale 1ns / 1ps
package twsv_pkg;

  localparam int COUNT_MAX_DEFAULT = 4095;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int TOTAL_W = 12;
  localparam int OUT_DATA_W = 4 * TOTAL_W;

  // word text is held as up to four lower-case letters, first letter lowest
  localparam logic [31:0] KW_AM   = {16'h0000, "m", "a"};
  localparam logic [31:0] KW_ARE  = {8'h00, "e", "r", "a"};
  localparam logic [31:0] KW_IS   = {16'h0000, "s", "i"};
  localparam logic [31:0] KW_WAS  = {8'h00, "s", "a", "w"};
  localparam logic [31:0] KW_WERE = {"e", "r", "e", "w"};
  localparam logic [31:0] KW_BE   = {16'h0000, "e", "b"};
  localparam logic [31:0] KW_TO   = {16'h0000, "o", "t"};

  localparam logic [2:0] LEN_TWO      = 3'd2;
  localparam logic [2:0] LEN_THREE    = 3'd3;
  localparam logic [2:0] LEN_FOUR     = 3'd4;
  localparam logic [2:0] LEN_TOO_LONG = 3'd5;

  typedef struct packed {
    logic [7:0] letter;
    logic       mark;
    logic       space;
    logic       last;
  } char_class_t;

endpackage

// ----- design/twsv_front.sv -----
`timescale 1ns / 1ps
module twsv_front (
  input  logic [7:0]            text_byte,
  input  logic                  final_byte,
  output twsv_pkg::char_class_t cls
);
  import twsv_pkg::*;

  always_comb begin
    cls.mark  = (text_byte == ".") || (text_byte == "?") || (text_byte == "!");
    cls.space = (text_byte == " ") || (text_byte == 8'h09) || (text_byte == 8'h0a);
    cls.last  = final_byte;
    if (text_byte >= "A" && text_byte <= "Z") begin
      cls.letter = text_byte + 8'h20;
    end else begin
      cls.letter = text_byte;
    end
  end

endmodule

// ----- design/twsv_queue.sv -----
`timescale 1ns / 1ps
module twsv_queue #(
  parameter int DEPTH = twsv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  twsv_pkg::char_class_t in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output twsv_pkg::char_class_t out_item
);
  import twsv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  char_class_t       mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CNTW-1:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != CNTW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/twsv_back.sv -----
`timescale 1ns / 1ps
module twsv_back #(
  parameter int COUNT_MAX = twsv_pkg::COUNT_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  twsv_pkg::char_class_t         in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [twsv_pkg::OUT_DATA_W-1:0] out_data
);
  import twsv_pkg::*;

  localparam int CW = ($clog2(COUNT_MAX + 1) > TOTAL_W) ? $clog2(COUNT_MAX + 1) : TOTAL_W;
  localparam logic [CW-1:0] CMAX = CW'(COUNT_MAX);

  logic [CW-1:0] chars_seen, chars_seen_next;
  logic [CW-1:0] words_seen, words_seen_next;
  logic [CW-1:0] sentences_seen, sentences_seen_next;
  logic [CW-1:0] verbs_seen, verbs_seen_next;
  logic          inside_word, inside_word_next;
  logic [31:0]   word_prefix, word_prefix_next;
  logic [2:0]    prefix_length, prefix_length_next;
  logic          prefix_closed, prefix_closed_next;
  logic          previous_was_to, previous_was_to_next;

  logic          fire;
  logic          word_end;
  logic          verb_hit;
  logic          is_to;
  logic [31:0]   upd_prefix;
  logic [2:0]    upd_length;

  // a final item needs the result register free or draining
  assign in_ready = !in_item.last || !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    upd_prefix         = word_prefix;
    upd_length         = prefix_length;
    prefix_closed_next = prefix_closed;
    inside_word_next   = inside_word;
    words_seen_next    = words_seen;
    word_end           = 1'b0;

    chars_seen_next = (chars_seen >= CMAX) ? chars_seen : chars_seen + 1'b1;
    sentences_seen_next = sentences_seen;
    if (in_item.mark && sentences_seen < CMAX) begin
      sentences_seen_next = sentences_seen + 1'b1;
    end

    if (in_item.space) begin
      word_end = inside_word;
    end else begin
      word_end = in_item.last;
      inside_word_next = 1'b1;
      if (!inside_word && words_seen < CMAX) begin
        words_seen_next = words_seen + 1'b1;
      end
      if (!prefix_closed) begin
        if (in_item.mark) begin
          prefix_closed_next = 1'b1;
        end else if (prefix_length < LEN_FOUR) begin
          upd_prefix[{prefix_length[1:0], 3'b000} +: 8] = in_item.letter;
          upd_length = prefix_length + 1'b1;
        end else begin
          upd_length = LEN_TOO_LONG;
        end
      end
    end

    verb_hit = (upd_length == LEN_TWO   && upd_prefix == KW_AM)
            || (upd_length == LEN_THREE && upd_prefix == KW_ARE)
            || (upd_length == LEN_TWO   && upd_prefix == KW_IS)
            || (upd_length == LEN_THREE && upd_prefix == KW_WAS)
            || (upd_length == LEN_FOUR  && upd_prefix == KW_WERE)
            || (previous_was_to && upd_length == LEN_TWO && upd_prefix == KW_BE);
    is_to = (upd_length == LEN_TWO && upd_prefix == KW_TO);

    verbs_seen_next      = verbs_seen;
    previous_was_to_next = previous_was_to;
    word_prefix_next     = upd_prefix;
    prefix_length_next   = upd_length;
    if (word_end) begin
      if (verb_hit && verbs_seen < CMAX) begin
        verbs_seen_next = verbs_seen + 1'b1;
      end
      previous_was_to_next = is_to;
      inside_word_next     = 1'b0;
      word_prefix_next     = '0;
      prefix_length_next   = '0;
      prefix_closed_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_seen      <= '0;
      words_seen      <= '0;
      sentences_seen  <= '0;
      verbs_seen      <= '0;
      inside_word     <= 1'b0;
      word_prefix     <= '0;
      prefix_length   <= '0;
      prefix_closed   <= 1'b0;
      previous_was_to <= 1'b0;
    end else if (fire) begin
      if (in_item.last) begin
        // paragraph done, start the next one clean
        chars_seen      <= '0;
        words_seen      <= '0;
        sentences_seen  <= '0;
        verbs_seen      <= '0;
        inside_word     <= 1'b0;
        word_prefix     <= '0;
        prefix_length   <= '0;
        prefix_closed   <= 1'b0;
        previous_was_to <= 1'b0;
      end else begin
        chars_seen      <= chars_seen_next;
        words_seen      <= words_seen_next;
        sentences_seen  <= sentences_seen_next;
        verbs_seen      <= verbs_seen_next;
        inside_word     <= inside_word_next;
        word_prefix     <= word_prefix_next;
        prefix_length   <= prefix_length_next;
        prefix_closed   <= prefix_closed_next;
        previous_was_to <= previous_was_to_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.last) begin
      out_data <= {verbs_seen_next[TOTAL_W-1:0], sentences_seen_next[TOTAL_W-1:0],
                   words_seen_next[TOTAL_W-1:0], chars_seen_next[TOTAL_W-1:0]};
    end
  end

endmodule

// ----- design/text_word_sentence_verb_counter_unit.sv -----
`timescale 1ns / 1ps
// channel  dir  signals                       contents
// s_*      in   tvalid tready tdata[7:0]      tdata: text_byte; tlast: final_byte
//                tlast
// m_*      out  tvalid tready tdata[47:0]     tdata: character_total, word_total,
//                                             sentence_total, to_be_total
//
// one byte per cycle while s_tready is high; a byte is classified on entry and counted
// after it leaves the queue, in the back end, which folds it into the counts
// the paragraph's totals appear on m_* the cycle after its last byte leaves the queue
// reset (rst, synchronous) clears the counts, the word state, the queue and the result valid
// a stalled result register holds back only a final byte; others keep flowing
module text_word_sentence_verb_counter_unit #(
  parameter int COUNT_MAX   = twsv_pkg::COUNT_MAX_DEFAULT,
  parameter int QUEUE_DEPTH = twsv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] text_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [11:0] character_total, [23:12] word_total, [35:24] sentence_total,
  // [47:36] to_be_total
  output logic [twsv_pkg::OUT_DATA_W-1:0] m_tdata
);
  import twsv_pkg::*;

  char_class_t front_cls;
  char_class_t q_item;
  logic        q_valid;
  logic        q_ready;

  twsv_front u_front (
    .text_byte  (s_tdata),
    .final_byte (s_tlast),
    .cls        (front_cls)
  );

  twsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (front_cls),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  twsv_back #(
    .COUNT_MAX (COUNT_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
